// ===== rtl/m3au_pkg.sv =====
// ----------------------------------------------------------------------------
// m3au_pkg: shared types and codes for the 3x3 matrix arithmetic unit
// Operation codes, command codes and sequencer state encoding.
// ----------------------------------------------------------------------------
package m3au_pkg;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_SADD = 3'd3,
    OP_SSUB = 3'd4,
    OP_SMUL = 3'd5,
    OP_SDIV = 3'd6,
    OP_NONE = 3'd7
  } op_t;

  localparam int ELEMS = 9;
  localparam int IDX_W = 4;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_MAC  = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

endpackage

// ===== rtl/matrix3x3_arith_unit_core.sv =====
// ----------------------------------------------------------------------------
// matrix3x3_arith_unit_core: 3x3 fixed-point matrix arithmetic unit
// Holds matrices A and B in two memories; load beats write one element pair,
// compute beats stream nine saturated result elements in row-major order.
// ----------------------------------------------------------------------------
// Sequence: a load beat is written to the memories directly. For a compute beat
//   each element goes through S_READ (addresses), then S_MAC for scalar multiply
//   and the matrix product (three reads through one multiplier) or S_DIV for a
//   divide, then S_FIN, which registers the result and raises m_tvalid, then S_OUT.
// Throughput: loads one per cycle while no compute is in progress; a compute holds
//   the input for nine element passes (plus output stalls).
// Reset: clears the sequencer and output valid; the matrix memories keep
//   whatever they hold and are undefined until loaded.
module matrix3x3_arith_unit_core #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // tuser: [0] command, [3:1] operation
  input  logic [3:0]                  s_tuser,
  // tdata: row_index, col_index, a_value, b_value, scalar_value, zero pad
  input  logic [((3*DATA_WIDTH+4+7)/8)*8-1:0] s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic                        m_tlast,
  // tuser: [0] saturated_flag, [1] divide_by_zero
  output logic [1:0]                  m_tuser,
  // tdata: out_row, out_col, out_value, zero pad
  output logic [((DATA_WIDTH+4+7)/8)*8-1:0] m_tdata
);
  import m3au_pkg::*;

  localparam int OW = ((DATA_WIDTH+4+7)/8)*8;
  localparam int PW = 2*DATA_WIDTH + 2;   // product/accumulator width
  localparam int QW = DATA_WIDTH + FRAC_BITS + 1;
  localparam logic signed [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // input field slices
  logic                          cmd;
  op_t                           op_in;
  logic [1:0]                    row_in, col_in;
  logic signed [DATA_WIDTH-1:0]  a_in, b_in, s_in;
  assign cmd    = s_tuser[0];
  assign op_in  = op_t'(s_tuser[3:1]);
  assign row_in = s_tdata[1:0];
  assign col_in = s_tdata[3:2];
  assign a_in   = s_tdata[4 +: DATA_WIDTH];
  assign b_in   = s_tdata[4+DATA_WIDTH +: DATA_WIDTH];
  assign s_in   = s_tdata[4+2*DATA_WIDTH +: DATA_WIDTH];

  // matrix memories, one read port each, registered read data
  logic signed [DATA_WIDTH-1:0] mem_a [ELEMS];
  logic signed [DATA_WIDTH-1:0] mem_b [ELEMS];
  logic [IDX_W-1:0]             ra_addr, rb_addr;
  logic signed [DATA_WIDTH-1:0] ra_data, rb_data;

  state_t                       state;
  op_t                          op;
  logic signed [DATA_WIDTH-1:0] scalar;
  logic [1:0]                   er, ec;   // element being produced
  logic [1:0]                   kk;       // product term index
  logic signed [PW-1:0]         acc;
  logic signed [PW-1:0]         prod;
  logic                         prod_v;
  logic                         prod_q2;
  logic                         div_start, div_done;
  logic signed [QW-1:0]         quot;
  logic signed [DATA_WIDTH-1:0]   mul_b;
  logic signed [2*DATA_WIDTH-1:0] mul_p;

  // final value select
  logic [DATA_WIDTH-1:0]        sat_val;
  logic                         sat_flag, dz_val;
  logic [DATA_WIDTH:0]          sw;

  logic in_fire, out_fire;
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;
  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (in_fire && cmd == CMD_LOAD && row_in < 2'd3 && col_in < 2'd3) begin
      mem_a[IDX_W'(row_in)*4'd3 + IDX_W'(col_in)] <= a_in;
      mem_b[IDX_W'(row_in)*4'd3 + IDX_W'(col_in)] <= b_in;
    end
    ra_data <= mem_a[ra_addr];
    rb_data <= mem_b[rb_addr];
  end

  // read addresses: elementwise ops use (er,ec); product walks row er of A
  // and column ec of B
  always_comb begin
    if (op == OP_MUL) begin
      ra_addr = IDX_W'(er)*4'd3 + IDX_W'(kk);
      rb_addr = IDX_W'(kk)*4'd3 + IDX_W'(ec);
    end else begin
      ra_addr = IDX_W'(er)*4'd3 + IDX_W'(ec);
      rb_addr = ra_addr;
    end
  end

  // one DATA_WIDTH x DATA_WIDTH signed multiplier, registered
  assign mul_b = (op == OP_MUL) ? rb_data : scalar;
  assign mul_p = ra_data * mul_b;

  always_ff @(posedge clk) begin
    prod <= PW'(mul_p);
  end

  m3au_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ra_data),
    .divisor  (scalar),
    .done     (div_done),
    .quotient (quot)
  );

  // elementwise sum, exact at DATA_WIDTH+1
  logic signed [DATA_WIDTH:0] esum;
  always_comb begin
    unique case (op)
      OP_ADD:  esum = (DATA_WIDTH+1)'(ra_data) + (DATA_WIDTH+1)'(rb_data);
      OP_SUB:  esum = (DATA_WIDTH+1)'(ra_data) - (DATA_WIDTH+1)'(rb_data);
      OP_SADD: esum = (DATA_WIDTH+1)'(ra_data) + (DATA_WIDTH+1)'(scalar);
      default: esum = (DATA_WIDTH+1)'(ra_data) - (DATA_WIDTH+1)'(scalar);
    endcase
  end

  // saturate a wide value to DATA_WIDTH
  function automatic logic [DATA_WIDTH:0] sat_w(input logic signed [PW-1:0] v);
    logic signed [DATA_WIDTH-1:0] lo;
    lo = v[DATA_WIDTH-1:0];
    if (v > PW'(VMAX))      sat_w = {1'b1, VMAX};
    else if (v < PW'(VMIN)) sat_w = {1'b1, VMIN};
    else                    sat_w = {1'b0, lo};
  endfunction

  logic signed [PW-1:0] shifted_acc;
  assign shifted_acc = acc >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      m_tvalid  <= 1'b0;
      div_start <= 1'b0;
      prod_v    <= 1'b0;
    end else begin
      // divider kick in the first S_DIV cycle, when read data is valid
      div_start <= (state == S_READ) && (op == OP_SDIV);
      // one product per address cycle
      prod_v    <= (state == S_READ) && (op == OP_MUL || op == OP_SMUL);
      // accumulator cleared between elements; products land after their address
      // has passed through the read-data and product registers
      if (state == S_IDLE || state == S_OUT) acc <= '0;
      else if (prod_q2) acc <= acc + prod;
      unique case (state)
        S_IDLE: begin
          if (in_fire && cmd == CMD_COMPUTE && op_in != OP_NONE) begin
            op     <= op_in;
            scalar <= s_in;
            er     <= 2'd0;
            ec     <= 2'd0;
            kk     <= 2'd0;
            state  <= S_READ;
          end
        end
        S_READ: begin
          // address presented this cycle, data next
          if (op == OP_MUL) begin
            if (kk == 2'd2) state <= S_MAC;
            else kk <= kk + 2'd1;
          end else if (op == OP_SMUL) begin
            state  <= S_MAC;
          end else if (op == OP_SDIV) begin
            state <= S_DIV;
          end else begin
            state <= S_FIN;
          end
        end
        S_MAC: begin
          // wait for remaining products to accumulate
          if (!prod_v) state <= S_FIN;
        end
        S_DIV: begin
          if (div_done) state <= S_FIN;
        end
        S_FIN: begin
          m_tvalid <= 1'b1;
          m_tdata  <= OW'({sat_val, ec, er});
          m_tuser  <= {dz_val, sat_flag};
          m_tlast  <= (er == 2'd2) && (ec == 2'd2);
          state    <= S_OUT;
        end
        S_OUT: begin
          if (out_fire) begin
            m_tvalid <= 1'b0;
            kk       <= 2'd0;
            if (er == 2'd2 && ec == 2'd2) state <= S_IDLE;
            else begin
              if (ec == 2'd2) begin
                ec <= 2'd0;
                er <= er + 2'd1;
              end else ec <= ec + 2'd1;
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // product alignment: address cycle -> ra_data -> prod register
  always_ff @(posedge clk) begin
    if (rst) prod_q2 <= 1'b0;
    else     prod_q2 <= prod_v;
  end

  always_comb begin
    dz_val = 1'b0;
    sw     = '0;
    unique case (op)
      OP_MUL, OP_SMUL: sw = sat_w(shifted_acc);
      OP_SDIV: begin
        if (scalar == '0) begin
          dz_val = 1'b1;
          sw     = {1'b1, ra_data[DATA_WIDTH-1] ? VMIN : VMAX};
        end else begin
          sw = sat_w(PW'(quot));
        end
      end
      default: sw = sat_w(PW'(esum));
    endcase
    sat_val  = sw[DATA_WIDTH-1:0];
    sat_flag = sw[DATA_WIDTH];
  end
endmodule

// ===== rtl/m3au_div.sv =====
// ----------------------------------------------------------------------------
// m3au_div: radix-2 restoring divider
// Signed (a << FRAC_BITS) / s, truncated toward zero, one quotient bit a cycle.
// Result is the full-width quotient; the caller saturates.
// ----------------------------------------------------------------------------
module m3au_div #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [DATA_WIDTH-1:0]          dividend,
  input  logic signed [DATA_WIDTH-1:0]          divisor,
  output logic                                  done,
  output logic signed [DATA_WIDTH+FRAC_BITS:0]  quotient
);
  localparam int NW = DATA_WIDTH + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]         num;
  logic [NW-1:0]         quo;
  logic [DATA_WIDTH:0]   rem;
  logic [DATA_WIDTH:0]   den;
  logic                  neg;
  logic [CW-1:0]         cnt;
  logic                  busy;
  logic [DATA_WIDTH+1:0] trial;
  logic [DATA_WIDTH+1:0] shifted;
  logic [NW-1:0]         num_abs;
  logic signed [NW:0]    num_ext;

  always_comb begin
    num_ext = {{(FRAC_BITS+1){dividend[DATA_WIDTH-1]}}, dividend} <<< FRAC_BITS;
    num_abs = dividend[DATA_WIDTH-1] ? NW'(-num_ext) : num_ext[NW-1:0];
    shifted = {rem, num[NW-1]};
    trial   = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= num_abs;
      quo <= '0;
      rem <= '0;
      den <= divisor[DATA_WIDTH-1] ? (DATA_WIDTH+1)'(-{divisor[DATA_WIDTH-1], divisor})
                                   : {1'b0, divisor};
      neg <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
    end else if (busy) begin
      num <= {num[NW-2:0], 1'b0};
      if (!trial[DATA_WIDTH+1]) begin
        rem <= trial[DATA_WIDTH:0];
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= shifted[DATA_WIDTH:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
endmodule

// ===== rtl/m3au_checker.sv =====
// ----------------------------------------------------------------------------
// m3au_checker: port-level checks for the matrix arithmetic unit
// Watches the stream ports only.
// ----------------------------------------------------------------------------
module m3au_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic       m_tlast,
  input logic [1:0] m_tuser
);
  // input is held off while a result is pending
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input accepted during output");
  // divide by zero always implies clamping
  a_dz_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0]) else $error("dz without sat");
  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tlast))
    else $error("output dropped");
endmodule

bind matrix3x3_arith_unit_core m3au_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast), .m_tuser(m_tuser)
);

// ===== bench/matrix3x3_arith_unit_core_test.sv =====
// ----------------------------------------------------------------------------
// matrix3x3_arith_unit_core_test: self-checking bench for the 3x3 matrix unit
// Loads A/B element pairs, then issues every operation. Each result beat is
// checked against a local Q16.16 model. Both sides idle at random, and there
// is one long output hold-off plus one drain pause. All A/B entries are
// loaded before the first compute, so no unwritten entry is ever read.
// ----------------------------------------------------------------------------
module matrix3x3_arith_unit_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import m3au_pkg::*;

  localparam logic signed [31:0] QMAX = 32'sh7fffffff;
  localparam logic signed [31:0] QMIN = 32'sh80000000;
  localparam logic signed [95:0] WMAX = 96'sd2147483647;
  localparam logic signed [95:0] WMIN = -96'sd2147483648;
  localparam int RAND_ITEMS = 240;
  localparam int LONG_HOLD  = 300;

  // one stimulus row; the t* fields give a typed first result beat
  typedef struct {
    logic             cmd;
    op_t              op;
    logic [1:0]       row;
    logic [1:0]       col;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] s;
    bit               typed;
    logic signed [31:0] tv;
    bit               tsat;
    bit               tdz;
  } stim_row_t;

  typedef struct {
    logic [1:0]       row;
    logic [1:0]       col;
    logic signed [31:0] value;
    bit               sat;
    bit               dz;
    bit               last;
  } elem_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [3:0]   s_tuser;   // [0] command, [3:1] operation
  logic [103:0] s_tdata;   // row, col, a_value, b_value, scalar_value, pad
  logic         m_tvalid;
  logic         m_tready;
  logic         m_tlast;
  logic [1:0]   m_tuser;   // [0] saturated_flag, [1] divide_by_zero
  logic [39:0]  m_tdata;   // out_row, out_col, out_value, pad

  logic signed [31:0] mat_a [9];
  logic signed [31:0] mat_b [9];
  elem_t     pending_elems [$];
  stim_row_t dir_tab [$];
  int        err_count = 0;
  bit        long_hold_req = 0;

  matrix3x3_arith_unit_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast),
    .m_tuser(m_tuser), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report(input string what);
    err_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // clamp a wide signed value to Q16.16
  function automatic logic signed [31:0] clamp(input logic signed [95:0] x,
                                               output bit sat);
    sat = 1'b0;
    if (x > WMAX) begin
      sat = 1'b1;
      return QMAX;
    end
    if (x < WMIN) begin
      sat = 1'b1;
      return QMIN;
    end
    return x[31:0];
  endfunction

  // apply one accepted beat to the local matrices, queue nine results on compute
  task automatic predict_beat(input stim_row_t it);
    int r, c;
    elem_t e;
    logic signed [95:0] acc;
    longint num, quo;
    if (it.cmd == CMD_LOAD) begin
      if (it.row < 3 && it.col < 3) begin
        mat_a[it.row*3 + it.col] = it.a;
        mat_b[it.row*3 + it.col] = it.b;
      end
      return;
    end
    if (it.op == OP_NONE) return;
    for (int k = 0; k < 9; k++) begin
      r = k / 3;
      c = k % 3;
      e.row = r[1:0];
      e.col = c[1:0];
      e.dz = 1'b0;
      e.last = (k == 8);
      case (it.op)
        OP_ADD:  e.value = clamp(96'(mat_a[k]) + 96'(mat_b[k]), e.sat);
        OP_SUB:  e.value = clamp(96'(mat_a[k]) - 96'(mat_b[k]), e.sat);
        OP_MUL: begin
          acc = 96'(mat_a[r*3]) * 96'(mat_b[c])
              + 96'(mat_a[r*3+1]) * 96'(mat_b[3+c])
              + 96'(mat_a[r*3+2]) * 96'(mat_b[6+c]);
          e.value = clamp(acc >>> 16, e.sat);
        end
        OP_SADD: e.value = clamp(96'(mat_a[k]) + 96'(it.s), e.sat);
        OP_SSUB: e.value = clamp(96'(mat_a[k]) - 96'(it.s), e.sat);
        OP_SMUL: e.value = clamp((96'(mat_a[k]) * 96'(it.s)) >>> 16, e.sat);
        default: begin
          if (it.s == 0) begin
            e.dz = 1'b1;
            e.sat = 1'b1;
            e.value = (mat_a[k] < 0) ? QMIN : QMAX;
          end else begin
            num = longint'(mat_a[k]) * 65536;
            quo = num / longint'(it.s);   // truncates toward zero
            e.value = clamp(96'(quo), e.sat);
          end
        end
      endcase
      if (k == 0 && it.typed) begin
        e.value = it.tv;
        e.sat = it.tsat;
        e.dz = it.tdz;
      end
      pending_elems.push_back(e);
    end
  endtask

  function automatic stim_row_t mk(input logic cmd, input op_t op, input int row,
                                   input int col, input logic signed [31:0] a,
                                   input logic signed [31:0] b,
                                   input logic signed [31:0] s);
    stim_row_t t;
    t.cmd = cmd; t.op = op; t.row = row[1:0]; t.col = col[1:0];
    t.a = a; t.b = b; t.s = s;
    t.typed = 1'b0; t.tv = '0; t.tsat = 1'b0; t.tdz = 1'b0;
    return t;
  endfunction

  // operand mix: extremes, zero, unit, small, anything
  function automatic logic signed [31:0] pick_val();
    case ($urandom_range(0, 7))
      0: return QMAX;
      1: return QMIN;
      2: return 32'sd0;
      3: return ($urandom_range(0, 1)) ? 32'sd65536 : -32'sd65536;
      4, 5: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
      default: return $urandom;
    endcase
  endfunction

  // drive one beat; valid stays high into the next beat when no gap follows
  task automatic send_beat(input stim_row_t it);
    int gap;
    s_tuser <= {it.op, it.cmd};
    s_tdata <= {4'b0, it.s, it.b, it.a, it.col, it.row};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_beat(it);
    gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side: random idling, one long hold-off on request
  initial begin
    int gap;
    elem_t e;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
      if (long_hold_req) begin
        long_hold_req = 0;
        gap = LONG_HOLD;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (pending_elems.size() == 0) begin
        report($sformatf("result beat with nothing pending, data %h", m_tdata));
      end else begin
        e = pending_elems.pop_front();
        if (m_tdata[1:0] !== e.row)
          report($sformatf("row %0d, want %0d", m_tdata[1:0], e.row));
        if (m_tdata[3:2] !== e.col)
          report($sformatf("col %0d, want %0d", m_tdata[3:2], e.col));
        if (m_tdata[35:4] !== e.value)
          report($sformatf("[%0d][%0d] value %h, want %h", e.row, e.col,
                           m_tdata[35:4], e.value));
        if (m_tuser[0] !== e.sat)
          report($sformatf("[%0d][%0d] saturated %b, want %b", e.row, e.col,
                           m_tuser[0], e.sat));
        if (m_tuser[1] !== e.dz)
          report($sformatf("[%0d][%0d] div-by-zero %b, want %b", e.row, e.col,
                           m_tuser[1], e.dz));
        if (m_tlast !== e.last)
          report($sformatf("[%0d][%0d] last %b, want %b", e.row, e.col,
                           m_tlast, e.last));
      end
    end
  end

  initial begin
    stim_row_t t;
    int wait_cnt;
    s_tvalid = 1'b0;
    s_tuser = '0;
    s_tdata = '0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // full load of both matrices, extremes spread over the entries
    dir_tab.push_back(mk(CMD_LOAD, OP_ADD,  0, 0, QMAX, QMAX, 0));
    dir_tab.push_back(mk(CMD_LOAD, OP_SUB,  0, 1, QMIN, QMAX, 0));
    dir_tab.push_back(mk(CMD_LOAD, OP_NONE, 0, 2, 0, QMIN, 0));
    dir_tab.push_back(mk(CMD_LOAD, OP_MUL,  1, 0, -1, QMIN, 0));
    dir_tab.push_back(mk(CMD_LOAD, OP_ADD,  1, 1, 32'sh10000, -1, 0));
    dir_tab.push_back(mk(CMD_LOAD, OP_ADD,  1, 2, 32'sh30000, 32'sh20000, 0));
    dir_tab.push_back(mk(CMD_LOAD, OP_ADD,  2, 0, QMIN, 0, 0));
    dir_tab.push_back(mk(CMD_LOAD, OP_ADD,  2, 1, QMAX, 32'sh18000, 0));
    dir_tab.push_back(mk(CMD_LOAD, OP_ADD,  2, 2, -32'sh10000, QMAX, 0));
    // out-of-range loads are dropped
    dir_tab.push_back(mk(CMD_LOAD, OP_ADD,  3, 0, 32'sh5, 32'sh5, 0));
    dir_tab.push_back(mk(CMD_LOAD, OP_ADD,  1, 3, 32'sh7, 32'sh7, 0));
    // add: max + max clamps high
    t = mk(CMD_COMPUTE, OP_ADD, 0, 0, 0, 0, 0);
    t.typed = 1; t.tv = QMAX; t.tsat = 1;
    dir_tab.push_back(t);
    dir_tab.push_back(mk(CMD_COMPUTE, OP_SUB,  0, 0, 0, 0, QMAX));
    dir_tab.push_back(mk(CMD_COMPUTE, OP_MUL,  3, 3, QMAX, QMIN, 0));
    dir_tab.push_back(mk(CMD_COMPUTE, OP_SADD, 0, 0, 0, 0, QMAX));
    dir_tab.push_back(mk(CMD_COMPUTE, OP_SSUB, 0, 0, 0, 0, QMIN));
    dir_tab.push_back(mk(CMD_COMPUTE, OP_SMUL, 0, 0, 0, 0, -32'sh18000));
    dir_tab.push_back(mk(CMD_COMPUTE, OP_SDIV, 0, 0, 0, 0, 32'sh8000));
    dir_tab.push_back(mk(CMD_COMPUTE, OP_SDIV, 0, 0, 0, 0, -1));
    // divide by zero: A[0][0] is max, so the first beat is max with both flags
    t = mk(CMD_COMPUTE, OP_SDIV, 0, 0, 0, 0, 0);
    t.typed = 1; t.tv = QMAX; t.tsat = 1; t.tdz = 1;
    dir_tab.push_back(t);
    // unused opcode: nothing comes out
    dir_tab.push_back(mk(CMD_COMPUTE, OP_NONE, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(CMD_COMPUTE, OP_SMUL, 0, 0, 0, 0, QMIN));

    foreach (dir_tab[i]) send_beat(dir_tab[i]);

    // random part: mostly loads, with a compute every few beats
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 80) long_hold_req = 1;
      if (n == 160) begin
        s_tvalid <= 1'b0;
        wait (pending_elems.size() == 0);
        @(posedge clk);
      end
      t.cmd = ($urandom_range(0, 6) == 0) ? CMD_COMPUTE : CMD_LOAD;
      t.op = op_t'($urandom_range(0, 7));
      t.row = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      t.col = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      t.a = pick_val();
      t.b = pick_val();
      t.s = pick_val();
      t.typed = 1'b0;
      send_beat(t);
    end
    s_tvalid <= 1'b0;

    wait_cnt = 0;
    while (pending_elems.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (100) @(posedge clk);
    if (err_count == 0 && pending_elems.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/m3au_pkg.sv
rtl/m3au_div.sv
rtl/matrix3x3_arith_unit_core.sv
rtl/m3au_checker.sv
bench/matrix3x3_arith_unit_core_test.sv
